@@ rtl/psps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane support point search package
// Shared widths, register codes, mode and side codes, reset values and the
// structures that pass between the pipeline stages.
// ----------------------------------------------------------------------------
package psps_pkg;

    localparam int COORD_W     = 32;
    localparam int INDEX_W     = 16;
    localparam int DIST_W      = 48;
    localparam int TOL_W       = 31;
    localparam int MODE_W      = 2;
    localparam int SIDE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int SUM_W       = PROD_W + 2;

    localparam int INDEX_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    localparam logic signed [COORD_W-1:0] NORMAL_X_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] NORMAL_Y_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] NORMAL_Z_RST = 32'sd65536;
    localparam logic signed [COORD_W-1:0] OFFSET_RST   = 32'sd0;
    localparam logic signed [COORD_W-1:0] FLOOR_RST    = 32'sd1;
    localparam logic [TOL_W-1:0]          TOL_RST      = 31'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X,
        CFG_NORMAL_Y,
        CFG_NORMAL_Z,
        CFG_PLANE_OFFSET,
        CFG_SEARCH_MODE,
        CFG_DISTANCE_FLOOR,
        CFG_SIDE_TOLERANCE
    } t_cfg_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_SIGNED,
        MODE_ABS,
        MODE_OFFSET
    } t_mode;

    typedef enum logic [SIDE_W-1:0] {
        SIDE_BELOW,
        SIDE_ON,
        SIDE_ABOVE
    } t_side;

    localparam logic [MODE_W-1:0] MODE_RST = MODE_SIGNED;

    typedef struct packed {
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
        logic signed [COORD_W-1:0] plane_offset;
        logic [MODE_W-1:0]         search_mode;
        logic [TOL_W-1:0]          side_tolerance;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [INDEX_W-1:0]        index;
        logic                      first;
        logic                      last;
    } t_point;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
        logic ld_c;
    } t_pipe_ctl;

    typedef struct packed {
        logic [SIDE_W-1:0]        side;
        logic signed [DIST_W-1:0] distance;
        logic signed [DIST_W-1:0] metric;
        logic                     strict;
        logic [INDEX_W-1:0]       index;
        logic                     first;
        logic                     last;
    } t_dist_info;

endpackage

@@ rtl/psps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane support point search channels
// Valid/ready channels for configuration writes, points and results.
// ----------------------------------------------------------------------------
interface psps_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [psps_pkg::CFG_IDX_W-1:0]       index;
    logic [psps_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface psps_pt_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psps_pkg::COORD_W-1:0]  point_x;
    logic signed [psps_pkg::COORD_W-1:0]  point_y;
    logic signed [psps_pkg::COORD_W-1:0]  point_z;
    logic [psps_pkg::INDEX_W-1:0]         point_index;
    logic                                 run_first;
    logic                                 run_last;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output point_index, output run_first, output run_last,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input point_index, input run_first, input run_last,
                    output ready);
endinterface

interface psps_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [psps_pkg::SIDE_W-1:0]          point_side;
    logic signed [psps_pkg::DIST_W-1:0]   point_distance;
    logic                                 best_valid;
    logic [psps_pkg::INDEX_W-1:0]         best_index;
    logic signed [psps_pkg::DIST_W-1:0]   best_distance;
    logic                                 run_done;

    modport source (output valid, output point_side, output point_distance,
                    output best_valid, output best_index, output best_distance,
                    output run_done, input ready);
    modport sink   (input valid, input point_side, input point_distance,
                    input best_valid, input best_index, input best_distance,
                    input run_done, output ready);
endinterface

@@ rtl/plane_support_point_search_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane support point search unit
// Streams Q16.16 points, reports each point's plane distance and side, and
// tracks the furthest point of the current run.
// ----------------------------------------------------------------------------
// Usage:
// Configuration beats on i_cfg write one register each (normal x, y, z,
// plane offset, search mode, distance floor, side tolerance); write them
// only while no point is in flight. i_cfg is always ready.
// Each point beat on i_pt produces exactly one result beat on o_res, in
// order. A point with run_first set restarts the search from the floor.
// Each accepted point passes through the input, products, distance and
// result registers in turn. The pipeline takes one point every cycle while
// o_res.ready is high; the rate is set by the four stage registers, each of
// which passes its point on whenever the next stage is empty or emptying.
// When the receiver holds o_res.ready low, each stage still fills if it is
// empty, so up to four points are held before i_pt.ready drops.
// Reset loads the register reset values, clears the running best to the
// reset floor and empties the pipeline.
// ----------------------------------------------------------------------------
module plane_support_point_search_unit #(
    parameter int INDEX_BITS = psps_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = psps_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psps_cfg_if.sink   i_cfg,
    psps_pt_if.sink    i_pt,
    psps_res_if.source o_res
);
    import psps_pkg::*;

    localparam int IDX_W = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;

    t_cfg                       r_cfg;
    logic signed [COORD_W-1:0]  r_floor;

    logic                       r_va;
    logic                       r_vb;
    logic                       r_vc;
    logic                       r_vd;
    logic                       rdy_a;
    logic                       rdy_b;
    logic                       rdy_c;
    logic                       rdy_d;
    t_pipe_ctl                  ctl;
    logic                       ld_d;

    t_point                     pt;
    t_dist_info                 info;

    logic signed [DIST_W-1:0]   r_best;
    logic                       r_have;
    logic [IDX_W-1:0]           r_bpt;
    logic [SIDE_W-1:0]          r_side;
    logic signed [DIST_W-1:0]   r_dist;
    logic                       r_done;

    logic signed [DIST_W-1:0]   base_best;
    logic                       take;
    logic signed [DIST_W-1:0]   n_best;
    logic                       n_have;
    logic [IDX_W-1:0]           n_bpt;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x       <= NORMAL_X_RST;
            r_cfg.normal_y       <= NORMAL_Y_RST;
            r_cfg.normal_z       <= NORMAL_Z_RST;
            r_cfg.plane_offset   <= OFFSET_RST;
            r_cfg.search_mode    <= MODE_RST;
            r_cfg.side_tolerance <= TOL_RST;
            r_floor              <= FLOOR_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_NORMAL_X:       r_cfg.normal_x       <= $signed(i_cfg.data);
                CFG_NORMAL_Y:       r_cfg.normal_y       <= $signed(i_cfg.data);
                CFG_NORMAL_Z:       r_cfg.normal_z       <= $signed(i_cfg.data);
                CFG_PLANE_OFFSET:   r_cfg.plane_offset   <= $signed(i_cfg.data);
                CFG_SEARCH_MODE:    r_cfg.search_mode    <= i_cfg.data[MODE_W-1:0];
                CFG_DISTANCE_FLOOR: r_floor              <= $signed(i_cfg.data);
                CFG_SIDE_TOLERANCE: r_cfg.side_tolerance <= i_cfg.data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign rdy_d      = !r_vd || o_res.ready;
    assign rdy_c      = !r_vc || rdy_d;
    assign rdy_b      = !r_vb || rdy_c;
    assign rdy_a      = !r_va || rdy_b;
    assign i_pt.ready = rdy_a;

    assign ctl.ld_a = i_pt.valid && rdy_a;
    assign ctl.ld_b = r_va && rdy_b;
    assign ctl.ld_c = r_vb && rdy_c;
    assign ld_d     = r_vc && rdy_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_pt.valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
            if (rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    assign pt.x     = i_pt.point_x;
    assign pt.y     = i_pt.point_y;
    assign pt.z     = i_pt.point_z;
    assign pt.index = i_pt.point_index;
    assign pt.first = i_pt.run_first;
    assign pt.last  = i_pt.run_last;

    psps_dot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dot (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_cfg  (r_cfg),
        .i_pt   (pt),
        .o_info (info)
    );

    always_comb begin
        base_best = info.first ? DIST_W'(r_floor) : r_best;
        if (info.strict) begin
            take = info.metric > base_best;
        end else begin
            take = info.metric >= base_best;
        end
        n_best = take ? info.metric : base_best;
        n_have = take || (!info.first && r_have);
        if (take) begin
            n_bpt = info.index[IDX_W-1:0];
        end else if (info.first) begin
            n_bpt = '0;
        end else begin
            n_bpt = r_bpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= DIST_W'(FLOOR_RST);
            r_have <= 1'b0;
            r_bpt  <= '0;
        end else if (ld_d) begin
            r_best <= n_best;
            r_have <= n_have;
            r_bpt  <= n_bpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_d) begin
            r_side <= info.side;
            r_dist <= info.distance;
            r_done <= info.last;
        end
    end

    assign o_res.valid          = r_vd;
    assign o_res.point_side     = r_side;
    assign o_res.point_distance = r_dist;
    assign o_res.best_valid     = r_have;
    assign o_res.best_index     = INDEX_W'(r_bpt);
    assign o_res.best_distance  = r_best;
    assign o_res.run_done       = r_done;

    a_reset_best: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_have && r_bpt == '0 && r_best == DIST_W'(FLOOR_RST))
        else $error("running best not cleared by reset");

    a_best_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ld_d |=> $stable(r_best) && $stable(r_have) && $stable(r_bpt))
        else $error("running best changed without a result load");

    a_first_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_d && info.first && !take) |=> !r_have && r_bpt == '0)
        else $error("run restart did not clear the winner");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_va && r_vb && r_vc && r_vd && !o_res.ready) |-> !i_pt.ready)
        else $error("point accepted into a full stalled pipeline");

    a_no_winner_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> r_bpt == '0)
        else $error("winner index set without a winner");

endmodule

@@ rtl/psps_dot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane support point search distance stages
// Input register, three registered products, then the saturated sum, side
// classification and search metric in a further register.
// ----------------------------------------------------------------------------
module psps_dot #(
    parameter int FRAC_BITS = psps_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  psps_pkg::t_pipe_ctl    i_ctl,
    input  psps_pkg::t_cfg         i_cfg,
    input  psps_pkg::t_point       i_pt,
    output psps_pkg::t_dist_info   o_info
);
    import psps_pkg::*;

    t_point                    r_pt_a;
    logic signed [PROD_W-1:0]  r_prod_x;
    logic signed [PROD_W-1:0]  r_prod_y;
    logic signed [PROD_W-1:0]  r_prod_z;
    logic [INDEX_W-1:0]        r_index_b;
    logic                      r_first_b;
    logic                      r_last_b;
    t_dist_info                r_info;

    logic signed [PROD_W-1:0]  sh_x;
    logic signed [PROD_W-1:0]  sh_y;
    logic signed [PROD_W-1:0]  sh_z;
    logic signed [SUM_W-1:0]   sum;
    logic signed [DIST_W-1:0]  dot_val;
    logic signed [DIST_W:0]    diff;
    logic signed [DIST_W+1:0]  diff_x;
    logic signed [DIST_W+1:0]  tol;
    t_dist_info                n_info;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_a) begin
            r_pt_a <= i_pt;
        end
        if (i_ctl.ld_b) begin
            r_prod_x  <= PROD_W'(r_pt_a.x * i_cfg.normal_x);
            r_prod_y  <= PROD_W'(r_pt_a.y * i_cfg.normal_y);
            r_prod_z  <= PROD_W'(r_pt_a.z * i_cfg.normal_z);
            r_index_b <= r_pt_a.index;
            r_first_b <= r_pt_a.first;
            r_last_b  <= r_pt_a.last;
        end
        if (i_ctl.ld_c) begin
            r_info <= n_info;
        end
    end

    always_comb begin
        sh_x = r_prod_x >>> FRAC_BITS;
        sh_y = r_prod_y >>> FRAC_BITS;
        sh_z = r_prod_z >>> FRAC_BITS;
        sum  = SUM_W'(sh_x) + SUM_W'(sh_y) + SUM_W'(sh_z);

        if (sum > SUM_W'(DIST_MAX)) begin
            dot_val = DIST_MAX;
        end else if (sum < SUM_W'(DIST_MIN)) begin
            dot_val = DIST_MIN;
        end else begin
            dot_val = sum[DIST_W-1:0];
        end

        diff   = (DIST_W+1)'(dot_val) - (DIST_W+1)'(i_cfg.plane_offset);
        diff_x = (DIST_W+2)'(diff);
        tol    = $signed((DIST_W+2)'(i_cfg.side_tolerance));

        n_info.distance = dot_val;
        n_info.index    = r_index_b;
        n_info.first    = r_first_b;
        n_info.last     = r_last_b;

        if (diff_x < -tol) begin
            n_info.side = SIDE_BELOW;
        end else if (diff_x > tol) begin
            n_info.side = SIDE_ABOVE;
        end else begin
            n_info.side = SIDE_ON;
        end

        case (i_cfg.search_mode)
            MODE_ABS: begin
                n_info.strict = 1'b0;
                if (!dot_val[DIST_W-1]) begin
                    n_info.metric = dot_val;
                end else if (dot_val == DIST_MIN) begin
                    n_info.metric = DIST_MAX;
                end else begin
                    n_info.metric = -dot_val;
                end
            end
            MODE_OFFSET: begin
                n_info.strict = 1'b1;
                if (diff > (DIST_W+1)'(DIST_MAX)) begin
                    n_info.metric = DIST_MAX;
                end else if (diff < (DIST_W+1)'(DIST_MIN)) begin
                    n_info.metric = DIST_MIN;
                end else begin
                    n_info.metric = diff[DIST_W-1:0];
                end
            end
            default: begin
                n_info.strict = 1'b0;
                n_info.metric = dot_val;
            end
        endcase
    end

    assign o_info = r_info;

endmodule

@@ tb/tb_plane_support_point_search_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane support point search unit testbench
// Drives streams of Q16.16 points through the unit under several register
// settings and predicts every result beat: the saturated plane distance, the
// side of the plane and the running winner of the current run. Each result
// beat is compared field by field with the oldest prediction. A short
// directed part covers saturation, floor rounding, ties, run restarts and a
// mode change in mid run; random runs follow, most with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_plane_support_point_search_unit;
    import psps_pkg::*;

    localparam logic [31:0] COORD_LO    = 32'h8000_0000;
    localparam logic [31:0] COORD_HI    = 32'h7FFF_FFFF;
    localparam logic [31:0] UNIT_Q16    = 32'h0001_0000;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam longint      DIST_HI     = DIST_MAX;
    localparam longint      DIST_LO     = DIST_MIN;
    localparam int          STALL_LIMIT = 2000;
    localparam int          SETTLE      = 8;

    typedef struct {
        t_side                    side;
        logic signed [DIST_W-1:0] distance;
        logic                     best_valid;
        logic [INDEX_W-1:0]       best_index;
        logic signed [DIST_W-1:0] best_dist;
        logic                     done;
    } t_search_result;

    logic i_clk;
    logic i_rst_n;

    psps_cfg_if cfg_bus ();
    psps_pt_if  pt_bus ();
    psps_res_if res_bus ();

    plane_support_point_search_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pt    (pt_bus),
        .o_res   (res_bus)
    );

    t_point         points_to_send[$];
    t_search_result verdicts_due[$];
    t_point         point_on_bus;

    int unsigned sender_idle_pct   = 33;
    int unsigned receiver_idle_pct = 73;
    int          mismatches        = 0;
    int          stall_cycles      = 0;

    logic signed [COORD_W-1:0] cfg_nx, cfg_ny, cfg_nz, cfg_offset, cfg_floor;
    logic [MODE_W-1:0]         cfg_mode;
    logic [TOL_W-1:0]          cfg_tol;
    longint                    best_metric;
    logic [INDEX_W-1:0]        best_idx;
    bit                        have_best;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clamp48(longint v);
        if (v > DIST_HI) return DIST_HI;
        if (v < DIST_LO) return DIST_LO;
        return v;
    endfunction

    function automatic longint plane_dot(t_point p);
        longint tx, ty, tz;
        tx = (longint'($signed(p.x)) * longint'(cfg_nx)) >>> FRAC_BITS_DEF;
        ty = (longint'($signed(p.y)) * longint'(cfg_ny)) >>> FRAC_BITS_DEF;
        tz = (longint'($signed(p.z)) * longint'(cfg_nz)) >>> FRAC_BITS_DEF;
        return clamp48(tx + ty + tz);
    endfunction

    function automatic t_search_result judge_point(t_point p);
        t_search_result r;
        longint point_dist, diff, tol, metric;
        bit take;
        point_dist = plane_dot(p);
        diff = point_dist - longint'(cfg_offset);
        tol  = longint'(cfg_tol);
        if (p.first) begin
            best_metric = longint'(cfg_floor);
            best_idx    = '0;
            have_best   = 1'b0;
        end
        if (diff < -tol) begin
            r.side = SIDE_BELOW;
        end else if (diff > tol) begin
            r.side = SIDE_ABOVE;
        end else begin
            r.side = SIDE_ON;
        end
        case (cfg_mode)
            MODE_ABS: begin
                metric = (point_dist < 0) ? clamp48(-point_dist) : point_dist;
                take   = metric >= best_metric;
            end
            MODE_OFFSET: begin
                metric = clamp48(diff);
                take   = metric > best_metric;
            end
            default: begin
                metric = point_dist;
                take   = metric >= best_metric;
            end
        endcase
        if (take) begin
            best_metric = metric;
            best_idx    = p.index;
            have_best   = 1'b1;
        end
        r.distance   = point_dist[DIST_W-1:0];
        r.best_valid = have_best;
        r.best_index = have_best ? best_idx : '0;
        r.best_dist  = best_metric[DIST_W-1:0];
        r.done       = p.last;
        return r;
    endfunction

    function automatic t_point make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic [15:0] idx, bit first, bit last);
        t_point p;
        p.x     = x;
        p.y     = y;
        p.z     = z;
        p.index = idx;
        p.first = first;
        p.last  = last;
        return p;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0: return COORD_LO;
                    1: return COORD_HI;
                    2: return 32'd0;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'd1;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return $urandom_range(2 ** 21) - (2 ** 20);
        endcase
    endfunction

    function automatic logic [31:0] rand_small();
        return $urandom_range(2 ** 19) - (2 ** 18);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatches++;
        end
    endfunction

    task automatic write_reg(t_cfg_reg idx, logic [31:0] value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_config(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                logic [31:0] offset, logic [31:0] mode,
                                logic [31:0] floor_val, logic [31:0] tol);
        write_reg(CFG_NORMAL_X, nx);
        write_reg(CFG_NORMAL_Y, ny);
        write_reg(CFG_NORMAL_Z, nz);
        write_reg(CFG_PLANE_OFFSET, offset);
        write_reg(CFG_SEARCH_MODE, mode);
        write_reg(CFG_DISTANCE_FLOOR, floor_val);
        write_reg(CFG_SIDE_TOLERANCE, tol);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (points_to_send.size() != 0 || pt_bus.valid || verdicts_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Mostly well-formed runs; the first run of a batch may continue the run
    // left open by the previous batch. Near-plane batches place z around the
    // offset so that the tolerance band and metric ties are hit often.
    task automatic queue_runs(int total, bit near, logic [31:0] center, int unsigned span);
        int     queued;
        int     len;
        bit     tidy;
        bit     open_run;
        t_point p;
        t_point prev;
        queued   = 0;
        open_run = 1'($urandom_range(1));
        prev     = make_point(rand_coord(), rand_coord(), rand_coord(), 16'd0, 1'b0, 1'b0);
        while (queued < total) begin
            len  = $urandom_range(1, 8);
            tidy = ($urandom_range(9) < 8);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(4) == 0) begin
                    p = prev;
                end else begin
                    p.x = rand_coord();
                    p.y = rand_coord();
                    p.z = rand_coord();
                    if (near)
                        p.z = center + ($urandom_range(2 * span) - span);
                end
                p.index = 16'($urandom_range(16'hFFFF));
                if (tidy) begin
                    p.first = (i == 0) && !open_run;
                    p.last  = (i == len - 1);
                end else begin
                    p.first = ($urandom_range(3) == 0);
                    p.last  = ($urandom_range(3) == 0);
                end
                points_to_send.push_back(p);
                prev = p;
            end
            open_run = 1'b0;
            queued += len;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_nx      = NORMAL_X_RST;
            cfg_ny      = NORMAL_Y_RST;
            cfg_nz      = NORMAL_Z_RST;
            cfg_offset  = OFFSET_RST;
            cfg_mode    = MODE_RST;
            cfg_floor   = FLOOR_RST;
            cfg_tol     = TOL_RST;
            best_metric = longint'(FLOOR_RST);
            best_idx    = '0;
            have_best   = 1'b0;
        end else if (cfg_bus.valid && cfg_bus.ready) begin
            case (t_cfg_reg'(cfg_bus.index))
                CFG_NORMAL_X:       cfg_nx     = cfg_bus.data;
                CFG_NORMAL_Y:       cfg_ny     = cfg_bus.data;
                CFG_NORMAL_Z:       cfg_nz     = cfg_bus.data;
                CFG_PLANE_OFFSET:   cfg_offset = cfg_bus.data;
                CFG_SEARCH_MODE:    cfg_mode   = cfg_bus.data[MODE_W-1:0];
                CFG_DISTANCE_FLOOR: cfg_floor  = cfg_bus.data;
                CFG_SIDE_TOLERANCE: cfg_tol    = cfg_bus.data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin : point_driver
        t_point nxt;
        if (!i_rst_n) begin
            pt_bus.valid <= 1'b0;
        end else begin
            if (pt_bus.valid && pt_bus.ready)
                verdicts_due.push_back(judge_point(point_on_bus));
            if (!pt_bus.valid || pt_bus.ready) begin
                if (points_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt                = points_to_send.pop_front();
                    point_on_bus       = nxt;
                    pt_bus.valid       <= 1'b1;
                    pt_bus.point_x     <= nxt.x;
                    pt_bus.point_y     <= nxt.y;
                    pt_bus.point_z     <= nxt.z;
                    pt_bus.point_index <= nxt.index;
                    pt_bus.run_first   <= nxt.first;
                    pt_bus.run_last    <= nxt.last;
                end else begin
                    pt_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_search_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result beat with no point waiting for it");
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("point_side", want.side, res_bus.point_side);
                    check_field("point_distance", want.distance, res_bus.point_distance);
                    check_field("best_valid", want.best_valid, res_bus.best_valid);
                    check_field("best_index", want.best_index, res_bus.best_index);
                    check_field("best_distance", want.best_dist, res_bus.best_distance);
                    check_field("run_done", want.done, res_bus.run_done);
                end
            end
            res_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_bus.valid && pt_bus.ready) || (res_bus.valid && res_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] center;
        logic [31:0] offset;
        int unsigned span;
        bit          near;
        i_rst_n            = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        pt_bus.valid       = 1'b0;
        pt_bus.point_x     = '0;
        pt_bus.point_y     = '0;
        pt_bus.point_z     = '0;
        pt_bus.point_index = '0;
        pt_bus.run_first   = 1'b0;
        pt_bus.run_last    = 1'b0;
        res_bus.ready      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: the distance equals z, floor one, tolerance one.
        points_to_send.push_back(make_point(COORD_LO, COORD_HI, 32'd0, 16'h0000, 1'b1, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, 32'd1, 16'hFFFF, 1'b0, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, 32'd2, 16'h1234, 1'b0, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, -32'sd2, 16'h4321, 1'b0, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, 32'd2, 16'h00AA, 1'b0, 1'b0));
        points_to_send.push_back(make_point(COORD_HI, COORD_LO, COORD_HI, 16'h5555, 1'b0, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, COORD_LO, 16'hAAAA, 1'b0, 1'b1));
        points_to_send.push_back(make_point(32'd0, 32'd0, -32'sd5, 16'h0F0F, 1'b1, 1'b1));
        points_to_send.push_back(make_point(32'd0, 32'd0, 32'd7, 16'hF0F0, 1'b0, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, 32'd3, 16'h0001, 1'b0, 1'b1));
        wait_idle();

        // Saturated sums, strict ties, then a mode change in mid run.
        write_config(COORD_LO, COORD_LO, COORD_LO, COORD_LO, MODE_OFFSET, COORD_LO, 32'd0);
        points_to_send.push_back(make_point(COORD_LO, COORD_LO, COORD_LO, 16'h0011, 1'b1, 1'b0));
        points_to_send.push_back(make_point(COORD_LO, COORD_LO, COORD_LO, 16'h0022, 1'b0, 1'b0));
        points_to_send.push_back(make_point(COORD_HI, COORD_HI, COORD_HI, 16'h0033, 1'b0, 1'b0));
        wait_idle();
        write_reg(CFG_SEARCH_MODE, MODE_ABS);
        points_to_send.push_back(make_point(COORD_HI, COORD_HI, COORD_HI, 16'h0044, 1'b0, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, 32'd0, 16'h0055, 1'b0, 1'b1));
        wait_idle();

        // A tiny normal shows the products rounding toward minus infinity.
        write_config(32'd0, 32'd0, 32'd1, -32'sd3, MODE_SIGNED, -32'sd10, 32'd2);
        points_to_send.push_back(make_point(32'd0, 32'd0, -32'sd1, 16'h0101, 1'b1, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, -32'sd65537, 16'h0202, 1'b0, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, 32'd65535, 16'h0303, 1'b0, 1'b0));
        points_to_send.push_back(make_point(32'd0, 32'd0, -32'sd393216, 16'h0404, 1'b0, 1'b1));

        for (int ph = 1; ph <= 8; ph++) begin
            wait_idle();
            if (ph == 3) begin
                sender_idle_pct   = 73;
                receiver_idle_pct = 33;
            end else if (ph == 6) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            near   = 1'b0;
            center = 32'd0;
            span   = 0;
            case (ph)
                1: write_config(rand_coord(), rand_coord(), rand_coord(), $urandom(), MODE_ABS,
                                rand_small(), $urandom());
                2: begin
                    offset = $urandom_range(2 ** 25) - (2 ** 24);
                    write_config(32'd0, 32'd0, UNIT_Q16, offset, MODE_OFFSET, COORD_LO, 32'd1000);
                    near   = 1'b1;
                    center = offset;
                    span   = 3000;
                end
                3: write_config(COORD_LO, COORD_HI, COORD_LO, $urandom(), MODE_SIGNED, COORD_HI,
                                32'hFFFF_FFFF);
                4: write_config(rand_small(), rand_small(), rand_small(), COORD_LO, MODE_UNUSED,
                                32'd0, 32'd0);
                5: write_config(rand_coord(), rand_coord(), rand_coord(), COORD_HI, MODE_OFFSET,
                                COORD_LO, $urandom());
                6: begin
                    write_config(32'd0, 32'd0, UNIT_Q16, 32'd0, MODE_ABS, 32'd0, 32'd200);
                    near = 1'b1;
                    span = 600;
                end
                7: write_config($urandom(), $urandom(), $urandom(), $urandom(), MODE_SIGNED,
                                $urandom(), $urandom());
                default: write_config(rand_coord(), rand_coord(), rand_coord(), rand_small(),
                                      MODE_OFFSET, rand_small(), $urandom_range(2 ** 18));
            endcase
            queue_runs(66, near, center, span);
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ plane_support_point_search_unit.f @@
rtl/psps_pkg.sv
rtl/psps_if.sv
rtl/psps_dot.sv
rtl/plane_support_point_search_unit.sv
tb/tb_plane_support_point_search_unit.sv
